### rtl/core/hkis_pkg.sv
`default_nettype none
package hkis_pkg;

    localparam int SLOT_COUNT_DEF    = 256;
    localparam int KEY_BYTES_MAX_DEF = 64;

    localparam logic [63:0] HASH_BASIS = 64'hCBF29CE484222325;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_KEY_LONG  = 3'd2;
    localparam logic [2:0] ST_BAD_SLOT  = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    localparam logic [1:0] REG_MAX_ENTRIES = 2'd0;
    localparam logic [1:0] REG_BASE_OFFSET = 2'd1;
    localparam logic [1:0] REG_HEADER_SIZE = 2'd2;

    // FNV-1a step; prime is 2^40 + 0x1B3, done as shifts and adds
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage
`default_nettype wire

### rtl/core/hkis_ram.sv
`default_nettype none
module hkis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### rtl/core/hashed_key_index_store.sv
`default_nettype none
// channel   direction  handshake                 payload
// in        input      in_valid / in_stall       mode key_byte key_last key_length key_kind
//                                                value_length slot_number
// out       output     out_valid / out_stall     status slot_index record_offset record_size
//                                                live_count key_hash
// cfg       input      cfg_we (no wait)          cfg_index cfg_data
//
// Key bytes are taken one per cycle while no command runs. The item with key_last holds
// input off while the command runs: a short key is padded with zero bytes, an insert
// copies its key bytes from the buffer to key memory, a delete clears the slot hash, and a
// lookup scans the slots and compares key bytes on hash candidates, the copy and compare
// steps waiting on the registered reads of the memories. Reset needs no clearing pass:
// slots at or above the used count read as zero. A stalled result holds while the next key
// streams in; the result of the command after it waits until the stalled result leaves.
module hashed_key_index_store
    import hkis_pkg::*;
#(
    parameter int SLOT_COUNT    = SLOT_COUNT_DEF,
    parameter int KEY_BYTES_MAX = KEY_BYTES_MAX_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [7:0]  key_byte,
    input  wire logic        key_last,
    input  wire logic [7:0]  key_length,
    input  wire logic [31:0] key_kind,
    input  wire logic [31:0] value_length,
    input  wire logic [7:0]  slot_number,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [7:0]       slot_index,
    output logic [47:0]      record_offset,
    output logic [47:0]      record_size,
    output logic [8:0]       live_count,
    output logic [63:0]      key_hash,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int SAW = $clog2(SLOT_COUNT);
    localparam int LW  = ($clog2(SLOT_COUNT + 1) > 9) ? $clog2(SLOT_COUNT + 1) : 9;
    localparam int BAW = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
    localparam int KAW = $clog2(SLOT_COUNT * KEY_BYTES_MAX);
    localparam int KW  = $clog2(KEY_BYTES_MAX + 1);
    localparam int AW  = KW + 32;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PAD    = 4'd1;
    localparam logic [3:0] S_EXEC   = 4'd2;
    localparam logic [3:0] S_CP_RD  = 4'd3;
    localparam logic [3:0] S_CP_WR  = 4'd4;
    localparam logic [3:0] S_SC_RD  = 4'd5;
    localparam logic [3:0] S_SC_CHK = 4'd6;
    localparam logic [3:0] S_CM_RD  = 4'd7;
    localparam logic [3:0] S_CM_CHK = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;

    logic [3:0]     state_reg;
    logic [8:0]     max_entries_reg;
    logic [7:0]     header_size_reg;
    logic [LW-1:0]  used_reg;
    logic [LW-1:0]  valid_cnt_reg;
    logic [47:0]    next_offset_reg;
    logic [KAW-1:0] used_kbase_reg;
    logic [63:0]    hash_reg;
    logic [7:0]     pos_reg;

    logic [1:0]     cmd_mode_reg;
    logic [7:0]     cmd_klen_reg;
    logic [31:0]    cmd_kind_reg;
    logic [31:0]    cmd_vlen_reg;
    logic [7:0]     cmd_slot_reg;

    logic [LW-1:0]  scan_reg;
    logic [KAW-1:0] kbase_reg;
    logic [7:0]     bidx_reg;

    logic [2:0]     res_status_reg;
    logic [7:0]     res_index_reg;
    logic [47:0]    res_offset_reg;
    logic [47:0]    res_size_reg;

    logic           out_valid_reg;
    logic [2:0]     out_status_reg;
    logic [7:0]     out_index_reg;
    logic [47:0]    out_offset_reg;
    logic [47:0]    out_size_reg;
    logic [8:0]     out_live_reg;
    logic [63:0]    out_hash_reg;

    logic           in_acc;
    logic           absorb_in;
    logic [63:0]    hash_in;
    logic [7:0]     pos_in;
    logic [LW-1:0]  limit;
    logic [47:0]    rsize;
    logic           ins_ok;
    logic           del_ok;
    logic [2:0]     exec_status;
    logic [3:0]     exec_state;

    logic           buf_we;
    logic [BAW-1:0] buf_waddr;
    logic [7:0]     buf_wdata;
    logic [7:0]     buf_rdata;
    logic           hash_we;
    logic [SAW-1:0] hash_waddr;
    logic [63:0]    hash_wdata;
    logic [63:0]    hash_rdata;
    logic           attr_we;
    logic [AW-1:0]  attr_rdata;
    logic           key_we;
    logic [KAW-1:0] key_addr;
    logic [7:0]     key_rdata;

    logic           in_range;
    logic [63:0]    slot_hash;
    logic [7:0]     slot_size;
    logic [31:0]    slot_kind;
    logic           cand;
    logic           out_free;

    assign in_acc    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign absorb_in = (pos_reg < key_length);
    assign hash_in   = absorb_in ? fnv_step(hash_reg, key_byte) : hash_reg;
    assign pos_in    = (absorb_in && pos_reg != 8'd255) ? pos_reg + 8'd1 : pos_reg;
    assign limit     = (LW'(max_entries_reg) > LW'(SLOT_COUNT)) ? LW'(SLOT_COUNT)
                                                                : LW'(max_entries_reg);
    assign rsize     = 48'(header_size_reg) + 48'(cmd_klen_reg) + 48'(cmd_vlen_reg);
    assign out_free  = !out_valid_reg || !out_stall;

    assign ins_ok = (cmd_mode_reg == MODE_INSERT) && (used_reg < limit)
                    && (cmd_klen_reg <= 8'(KEY_BYTES_MAX));
    assign del_ok = (cmd_mode_reg == MODE_DELETE) && (LW'(cmd_slot_reg) < limit);

    // slots never filled read as zero through the used-count check, not from a memory reset
    assign in_range  = (scan_reg < used_reg);
    assign slot_hash = in_range ? hash_rdata : 64'd0;
    assign slot_size = in_range ? 8'(attr_rdata[AW-1:32]) : 8'd0;
    assign slot_kind = in_range ? attr_rdata[31:0] : 32'd0;
    assign cand      = (slot_hash == hash_reg) && (slot_size == cmd_klen_reg)
                       && (slot_kind == cmd_kind_reg)
                       && (cmd_klen_reg <= 8'(KEY_BYTES_MAX));

    always_comb
    begin
        exec_status = ST_OK;
        exec_state  = S_EMIT;
        case (cmd_mode_reg)
            MODE_INSERT:
            begin
                if (used_reg >= limit)
                begin
                    exec_status = ST_FULL;
                end
                else if (cmd_klen_reg > 8'(KEY_BYTES_MAX))
                begin
                    exec_status = ST_KEY_LONG;
                end
                else if (cmd_klen_reg != 8'd0)
                begin
                    exec_state = S_CP_RD;
                end
            end
            MODE_DELETE:
            begin
                if (!del_ok)
                begin
                    exec_status = ST_BAD_SLOT;
                end
            end
            default:
            begin
                exec_state = S_SC_RD;
            end
        endcase
    end

    always_comb
    begin
        buf_we    = 1'b0;
        buf_waddr = pos_reg[BAW-1:0];
        buf_wdata = 8'd0;
        if (state_reg == S_IDLE && in_acc && absorb_in && pos_reg < 8'(KEY_BYTES_MAX))
        begin
            buf_we    = 1'b1;
            buf_wdata = key_byte;
        end
        else if (state_reg == S_PAD && pos_reg < 8'(KEY_BYTES_MAX))
        begin
            buf_we = 1'b1;
        end
    end

    always_comb
    begin
        hash_we    = 1'b0;
        attr_we    = 1'b0;
        hash_waddr = used_reg[SAW-1:0];
        hash_wdata = hash_reg;
        if (state_reg == S_EXEC)
        begin
            if (ins_ok)
            begin
                hash_we = 1'b1;
                attr_we = 1'b1;
            end
            else if (del_ok)
            begin
                hash_we    = 1'b1;
                hash_waddr = SAW'(cmd_slot_reg);
                hash_wdata = 64'd0;
            end
        end
    end

    assign key_we   = (state_reg == S_CP_WR);
    assign key_addr = kbase_reg + KAW'(bidx_reg);

    hkis_ram #(.WIDTH(8), .DEPTH(KEY_BYTES_MAX)) u_key_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .raddr (bidx_reg[BAW-1:0]),
        .rdata (buf_rdata)
    );

    hkis_ram #(.WIDTH(64), .DEPTH(SLOT_COUNT)) u_hash_ram (
        .clk   (clk),
        .we    (hash_we),
        .waddr (hash_waddr),
        .wdata (hash_wdata),
        .raddr (scan_reg[SAW-1:0]),
        .rdata (hash_rdata)
    );

    hkis_ram #(.WIDTH(AW), .DEPTH(SLOT_COUNT)) u_attr_ram (
        .clk   (clk),
        .we    (attr_we),
        .waddr (used_reg[SAW-1:0]),
        .wdata ({KW'(cmd_klen_reg), cmd_kind_reg}),
        .raddr (scan_reg[SAW-1:0]),
        .rdata (attr_rdata)
    );

    hkis_ram #(.WIDTH(8), .DEPTH(SLOT_COUNT * KEY_BYTES_MAX)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_addr),
        .wdata (buf_rdata),
        .raddr (key_addr),
        .rdata (key_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            max_entries_reg <= 9'd256;
            header_size_reg <= 8'd24;
            used_reg        <= '0;
            valid_cnt_reg   <= '0;
            next_offset_reg <= 48'd0;
            used_kbase_reg  <= '0;
            hash_reg        <= HASH_BASIS;
            pos_reg         <= 8'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (state_reg == S_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAX_ENTRIES: max_entries_reg <= cfg_data[8:0];
                    REG_BASE_OFFSET:
                    begin
                        if (used_reg == '0)
                        begin
                            next_offset_reg <= 48'(cfg_data);
                        end
                    end
                    REG_HEADER_SIZE: header_size_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        cmd_mode_reg <= mode;
                        cmd_klen_reg <= key_length;
                        cmd_kind_reg <= key_kind;
                        cmd_vlen_reg <= value_length;
                        cmd_slot_reg <= slot_number;
                        if (key_last
                            && !(mode inside {MODE_INSERT, MODE_DELETE, MODE_LOOKUP}))
                        begin
                            hash_reg <= HASH_BASIS;
                            pos_reg  <= 8'd0;
                        end
                        else
                        begin
                            hash_reg <= hash_in;
                            pos_reg  <= pos_in;
                        end
                        if (key_last && (mode inside {MODE_INSERT, MODE_DELETE, MODE_LOOKUP}))
                        begin
                            if (pos_in < key_length)
                            begin
                                state_reg <= S_PAD;
                            end
                            else
                            begin
                                state_reg <= S_EXEC;
                            end
                        end
                    end
                end

                S_PAD:
                begin
                    hash_reg <= fnv_step(hash_reg, 8'd0);
                    pos_reg  <= pos_reg + 8'd1;
                    if (pos_reg + 8'd1 >= cmd_klen_reg)
                    begin
                        state_reg <= S_EXEC;
                    end
                end

                S_EXEC:
                begin
                    res_status_reg <= exec_status;
                    res_index_reg  <= ins_ok ? 8'(used_reg) : (del_ok ? cmd_slot_reg : 8'd0);
                    res_offset_reg <= ins_ok ? next_offset_reg : 48'd0;
                    res_size_reg   <= ins_ok ? rsize : 48'd0;
                    bidx_reg       <= 8'd0;
                    scan_reg       <= '0;
                    kbase_reg      <= ins_ok ? used_kbase_reg : '0;
                    state_reg      <= exec_state;
                    if (ins_ok)
                    begin
                        next_offset_reg <= next_offset_reg + rsize;
                        used_reg        <= used_reg + LW'(1);
                        valid_cnt_reg   <= valid_cnt_reg + LW'(1);
                        used_kbase_reg  <= used_kbase_reg + KAW'(KEY_BYTES_MAX);
                    end
                    else if (del_ok && valid_cnt_reg != '0)
                    begin
                        valid_cnt_reg <= valid_cnt_reg - LW'(1);
                    end
                end

                S_CP_RD:
                begin
                    state_reg <= S_CP_WR;
                end

                S_CP_WR:
                begin
                    if (bidx_reg + 8'd1 == cmd_klen_reg)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        bidx_reg  <= bidx_reg + 8'd1;
                        state_reg <= S_CP_RD;
                    end
                end

                S_SC_RD:
                begin
                    if (scan_reg >= limit)
                    begin
                        res_status_reg <= ST_NOT_FOUND;
                        state_reg      <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_SC_CHK;
                    end
                end

                S_SC_CHK:
                begin
                    bidx_reg <= 8'd0;
                    if (cand && cmd_klen_reg == 8'd0)
                    begin
                        res_index_reg <= 8'(scan_reg);
                        state_reg     <= S_EMIT;
                    end
                    else if (cand)
                    begin
                        state_reg <= S_CM_RD;
                    end
                    else
                    begin
                        scan_reg  <= scan_reg + LW'(1);
                        kbase_reg <= kbase_reg + KAW'(KEY_BYTES_MAX);
                        state_reg <= S_SC_RD;
                    end
                end

                S_CM_RD:
                begin
                    state_reg <= S_CM_CHK;
                end

                S_CM_CHK:
                begin
                    if (key_rdata != buf_rdata)
                    begin
                        scan_reg  <= scan_reg + LW'(1);
                        kbase_reg <= kbase_reg + KAW'(KEY_BYTES_MAX);
                        state_reg <= S_SC_RD;
                    end
                    else if (bidx_reg + 8'd1 == cmd_klen_reg)
                    begin
                        res_index_reg <= 8'(scan_reg);
                        state_reg     <= S_EMIT;
                    end
                    else
                    begin
                        bidx_reg  <= bidx_reg + 8'd1;
                        state_reg <= S_CM_RD;
                    end
                end

                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_status_reg <= res_status_reg;
                        out_index_reg  <= res_index_reg;
                        out_offset_reg <= res_offset_reg;
                        out_size_reg   <= res_size_reg;
                        out_live_reg   <= 9'(valid_cnt_reg);
                        out_hash_reg   <= hash_reg;
                        hash_reg       <= HASH_BASIS;
                        pos_reg        <= 8'd0;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign slot_index    = out_index_reg;
    assign record_offset = out_offset_reg;
    assign record_size   = out_size_reg;
    assign live_count    = out_live_reg;
    assign key_hash      = out_hash_reg;

endmodule
`default_nettype wire
